>>> hw/rtl/sesb_pkg.sv
`default_nettype none

package sesb_pkg;

    // Store and radius limits
    localparam int MAX_FRAME_W      = 64;
    localparam int MAX_FRAME_H      = 64;
    localparam int MAX_STROKE_WIDTH = 16;

    localparam int COL_W   = $clog2(MAX_FRAME_W);
    localparam int ROW_W   = $clog2(MAX_FRAME_H);
    localparam int RAD_W   = $clog2(MAX_STROKE_WIDTH + 1);
    localparam int FW_W    = $clog2(MAX_FRAME_W + 1);
    localparam int FH_W    = $clog2(MAX_FRAME_H + 1);
    localparam int MAX_DIM = (MAX_FRAME_W > MAX_FRAME_H) ? MAX_FRAME_W : MAX_FRAME_H;
    // signed coordinate: covers -radius .. max_dim - 1 + radius
    localparam int COORD_W = $clog2(MAX_DIM + MAX_STROKE_WIDTH + 1) + 1;

    // Fixed field and register widths
    localparam int POS_FIELD_W  = 6;
    localparam int STROKE_CFG_W = 5;
    localparam int POS_CFG_W    = 2;
    localparam int FRAME_CFG_W  = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STROKE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STROKE_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd3;

    // Stroke position codes
    localparam logic [POS_CFG_W-1:0] POS_INSIDE  = 2'd0;
    localparam logic [POS_CFG_W-1:0] POS_CENTER  = 2'd1;
    localparam logic [POS_CFG_W-1:0] POS_OUTSIDE = 2'd2;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/selection_edge_stroke_band_unit.sv
`default_nettype none

// Selection edge stroke band. Keeps a 64x64 one-bit selection mask as 64 row
// words in a single-port-write / single-port-read memory with a registered
// read; 64 row valid flops make the whole mask read as zero right after reset,
// so no clearing pass is needed. A write item passes through a row read state
// and then a row write-back state that changes one bit, and gives no result.
// A query item scans the rows of the outer window and then the rows of the
// inner window through one shared row evaluator, one row word per cycle, then
// folds in the last row evaluation and loads the result into the output
// register once that is free. s_axis_tready is high only while the sequencer
// is idle. The result sits in an output register, so the next item can be
// accepted while it waits to be taken. The user must write configuration
// registers only while the block is idle; the block itself does not enforce this.
module selection_edge_stroke_band_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // Configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [sesb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sesb_pkg::CFG_DATA_W-1:0]       cfg_data,

    // Input items
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [0] operation, [6:1] pos_x, [12:7] pos_y, [13] selected, [15:14] zero
    input  wire logic [sesb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,

    // Result items
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [0] in_stroke, [1] near_selection, [2] fully_inside, [7:3] zero
    output logic [sesb_pkg::OUT_TDATA_W-1:0]           m_axis_tdata
);

    localparam int COORD_W = sesb_pkg::COORD_W;
    localparam int RAD_W   = sesb_pkg::RAD_W;
    localparam int ROW_W   = sesb_pkg::ROW_W;
    localparam int COL_W   = sesb_pkg::COL_W;
    localparam int MFW     = sesb_pkg::MAX_FRAME_W;
    localparam int MFH     = sesb_pkg::MAX_FRAME_H;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // ---------------- configuration registers ----------------
    logic [sesb_pkg::STROKE_CFG_W-1:0] stroke_width_reg;
    logic [sesb_pkg::POS_CFG_W-1:0]    stroke_position_reg;
    logic [sesb_pkg::FRAME_CFG_W-1:0]  frame_width_reg;
    logic [sesb_pkg::FRAME_CFG_W-1:0]  frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stroke_width_reg    <= sesb_pkg::STROKE_CFG_W'(1);
            stroke_position_reg <= sesb_pkg::POS_INSIDE;
            frame_width_reg     <= sesb_pkg::FRAME_CFG_W'(64);
            frame_height_reg    <= sesb_pkg::FRAME_CFG_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sesb_pkg::REG_STROKE_WIDTH:
                    stroke_width_reg <= cfg_data[sesb_pkg::STROKE_CFG_W-1:0];
                sesb_pkg::REG_STROKE_POSITION:
                    stroke_position_reg <= cfg_data[sesb_pkg::POS_CFG_W-1:0];
                sesb_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[sesb_pkg::FRAME_CFG_W-1:0];
                sesb_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[sesb_pkg::FRAME_CFG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------- derived radii and frame ----------------
    logic [RAD_W-1:0]          eff_w;
    logic [RAD_W-1:0]          r_out;
    logic [RAD_W-1:0]          r_in;
    logic [sesb_pkg::FW_W-1:0] fw;
    logic [sesb_pkg::FH_W-1:0] fh;

    always_comb
    begin
        // zero width acts as one, oversize saturates
        if (stroke_width_reg == '0)
            eff_w = RAD_W'(1);
        else if (int'(stroke_width_reg) > sesb_pkg::MAX_STROKE_WIDTH)
            eff_w = RAD_W'(sesb_pkg::MAX_STROKE_WIDTH);
        else
            eff_w = RAD_W'(stroke_width_reg);

        case (stroke_position_reg)
            sesb_pkg::POS_OUTSIDE:
            begin
                r_out = eff_w;
                r_in  = '0;
            end
            sesb_pkg::POS_CENTER:
            begin
                r_in  = eff_w >> 1;
                r_out = eff_w - (eff_w >> 1);
            end
            default:
            begin
                // inside, and the unused code three
                r_out = '0;
                r_in  = eff_w;
            end
        endcase

        fw = (int'(frame_width_reg) > MFW) ? sesb_pkg::FW_W'(MFW)
                                            : sesb_pkg::FW_W'(frame_width_reg);
        fh = (int'(frame_height_reg) > MFH) ? sesb_pkg::FH_W'(MFH)
                                             : sesb_pkg::FH_W'(frame_height_reg);
    end

    // ---------------- input unpacking ----------------
    logic                             in_op;
    logic [sesb_pkg::POS_FIELD_W-1:0] in_x;
    logic [sesb_pkg::POS_FIELD_W-1:0] in_y;
    logic                             in_sel;

    assign in_op  = s_axis_tdata[0];
    assign in_x   = s_axis_tdata[6:1];
    assign in_y   = s_axis_tdata[12:7];
    assign in_sel = s_axis_tdata[13];

    // ---------------- sequencer registers ----------------
    state_t                           state_reg;
    logic [sesb_pkg::POS_FIELD_W-1:0] cx_reg;
    logic [sesb_pkg::POS_FIELD_W-1:0] cy_reg;
    logic                             sel_reg;
    logic                             pass_reg;      // 0 outer window, 1 inner
    logic signed [COORD_W-1:0]        d_reg;         // row offset in window
    logic                             ev_valid_reg;
    logic                             ev_pass_reg;
    logic                             ev_rowok_reg;
    logic                             ev_vld_reg;
    logic                             near_acc_reg;
    logic                             full_acc_reg;
    logic                             out_valid_reg;
    logic [2:0]                       out_bits_reg;
    logic [MFH-1:0]                   vld_reg;       // row written since reset

    // ---------------- mask memory ----------------
    logic [MFW-1:0]   mem [MFH];
    logic [MFW-1:0]   mem_rdata_reg;
    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    logic [MFW-1:0]   mem_wdata;
    logic [ROW_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    // ---------------- address and row issue ----------------
    logic [RAD_W-1:0]          cur_r;
    logic signed [COORD_W-1:0] rd_row;
    logic                      rd_rowok;
    logic [MFW-1:0]            row_data;
    logic                      wr_in_store;

    assign cur_r    = pass_reg ? r_in : r_out;
    assign rd_row   = $signed(COORD_W'(cy_reg)) + d_reg;
    assign rd_rowok = (rd_row >= 0) && (rd_row < $signed(COORD_W'(fh)));
    assign row_data = ev_vld_reg ? mem_rdata_reg : '0;
    assign wr_in_store = (int'(cx_reg) < MFW) && (int'(cy_reg) < MFH);

    always_comb
    begin
        mem_raddr = (state_reg == ST_WR_RD) ? ROW_W'(cy_reg) : rd_row[ROW_W-1:0];
        mem_we    = (state_reg == ST_WR_WB) && wr_in_store;
        mem_waddr = ROW_W'(cy_reg);
        mem_wdata = row_data;
        mem_wdata[COL_W'(cx_reg)] = sel_reg;
    end

    // ---------------- shared row evaluator ----------------
    logic [RAD_W-1:0]          ev_r;
    logic signed [COORD_W-1:0] col_lo;
    logic signed [COORD_W-1:0] col_hi;
    logic [MFW-1:0]            col_mask;
    logic                      col_ok;
    logic                      row_hit;
    logic                      row_full;

    always_comb
    begin
        ev_r   = ev_pass_reg ? r_in : r_out;
        col_lo = $signed(COORD_W'(cx_reg)) - $signed(COORD_W'(ev_r));
        col_hi = $signed(COORD_W'(cx_reg)) + $signed(COORD_W'(ev_r));
        for (int c = 0; c < MFW; c++)
        begin
            col_mask[c] = ($signed(COORD_W'(c)) >= col_lo)
                       && ($signed(COORD_W'(c)) <= col_hi)
                       && (c < int'(fw));
        end
        // the inner window must not reach past the frame sideways
        col_ok   = (col_lo >= 0) && (col_hi < $signed(COORD_W'(fw)));
        row_hit  = ev_rowok_reg && ((row_data & col_mask) != '0);
        row_full = ev_rowok_reg && col_ok && ((row_data & col_mask) == col_mask);
    end

    // ---------------- sequencer ----------------
    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            sel_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            d_reg         <= '0;
            ev_valid_reg  <= 1'b0;
            ev_pass_reg   <= 1'b0;
            ev_rowok_reg  <= 1'b0;
            ev_vld_reg    <= 1'b0;
            near_acc_reg  <= 1'b0;
            full_acc_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            out_bits_reg  <= '0;
            vld_reg       <= '0;
        end
        else
        begin
            if (m_axis_tready)
                out_valid_reg <= 1'b0;

            // row evaluation, in the cycle after the row read is issued
            ev_valid_reg <= 1'b0;
            if (ev_valid_reg)
            begin
                if (ev_pass_reg)
                    full_acc_reg <= full_acc_reg & row_full;
                else
                    near_acc_reg <= near_acc_reg | row_hit;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cx_reg       <= in_x;
                        cy_reg       <= in_y;
                        sel_reg      <= in_sel;
                        pass_reg     <= 1'b0;
                        d_reg        <= -$signed(COORD_W'(r_out));
                        near_acc_reg <= 1'b0;
                        full_acc_reg <= 1'b1;
                        state_reg    <= (in_op == sesb_pkg::OP_WRITE) ? ST_WR_RD : ST_SCAN;
                    end
                end
                ST_WR_RD:
                begin
                    ev_vld_reg <= vld_reg[ROW_W'(cy_reg)];
                    state_reg  <= ST_WR_WB;
                end
                ST_WR_WB:
                begin
                    if (wr_in_store)
                        vld_reg[ROW_W'(cy_reg)] <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    ev_valid_reg <= 1'b1;
                    ev_pass_reg  <= pass_reg;
                    ev_rowok_reg <= rd_rowok;
                    ev_vld_reg   <= vld_reg[rd_row[ROW_W-1:0]];
                    if (d_reg == $signed(COORD_W'(cur_r)))
                    begin
                        if (!pass_reg)
                        begin
                            pass_reg <= 1'b1;
                            d_reg    <= -$signed(COORD_W'(r_in));
                        end
                        else
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        d_reg <= d_reg + COORD_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    // last inner row is folded in this cycle
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bits_reg  <= {full_acc_reg, near_acc_reg,
                                          near_acc_reg & ~full_acc_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sesb_pkg::OUT_TDATA_W-3){1'b0}}, out_bits_reg};

    // ---------------- assertions ----------------
    // no row evaluation may be left over when a new item can enter
    a_idle_no_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ev_valid_reg)
        else $error("row evaluation pending while idle");

    // a written row is marked valid after write-back
    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR_WB) && wr_in_store |=> vld_reg[$past(ROW_W'(cy_reg))])
        else $error("row valid bit not set after write");

    // a new scan starts with an empty outer accumulator
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && ($past(state_reg) == ST_IDLE) |-> !near_acc_reg)
        else $error("outer accumulator not cleared at scan start");

    // a finished query with a free output slot presents its result next cycle
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("query result not delivered");

endmodule

`default_nettype wire
